// ----- hdl/dats_pkg.sv -----
`default_nettype none
package dats_pkg;

  typedef struct packed {
    logic [1:0]  action;
    logic [2:0]  out_channels;
    logic [2:0]  in_channels;
    logic [15:0] frames_per_half;
    logic [15:0] rate_hz;
    logic [1:0]  irq_flags;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       page_high;
    logic       is_recording;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  action;
    logic        err_v;
    logic [2:0]  err;
    logic        rec;
    logic        stereo;
    logic [15:0] bsm1;
    logic [15:0] rate;
    logic [16:0] eff;
    logic [1:0]  irq;
  } cls_t;

  localparam logic [1:0] A_START = 2'd0;
  localparam logic [1:0] A_STOP  = 2'd1;
  localparam logic [1:0] A_IRQ   = 2'd2;

  localparam logic [1:0] CFG_MAJOR = 2'd0;
  localparam logic [1:0] CFG_MINOR = 2'd1;
  localparam logic [1:0] CFG_S16   = 2'd2;

  localparam logic [2:0] K_CMD   = 3'd0;
  localparam logic [2:0] K_RESET = 3'd1;
  localparam logic [2:0] K_ACK   = 3'd2;
  localparam logic [2:0] K_READY = 3'd3;
  localparam logic [2:0] K_ERR   = 3'd4;

  localparam logic [2:0] RS_IDLE     = 3'd0;
  localparam logic [2:0] RS_STOPPING = 3'd1;
  localparam logic [2:0] RS_SINGLE   = 3'd2;
  localparam logic [2:0] RS_SB16_8   = 3'd3;
  localparam logic [2:0] RS_LEGACY_8 = 3'd4;
  localparam logic [2:0] RS_HS       = 3'd5;
  localparam logic [2:0] RS_DMA16    = 3'd6;

  localparam logic [2:0] E_BUSY   = 3'd0;
  localparam logic [2:0] E_CHAN   = 3'd1;
  localparam logic [2:0] E_STEREO = 3'd2;
  localparam logic [2:0] E_DUPLEX = 3'd3;
  localparam logic [2:0] E_NODIR  = 3'd4;
  localparam logic [2:0] E_ZERO   = 3'd5;
  localparam logic [2:0] E_BIG    = 3'd6;
  localparam logic [2:0] E_RATE   = 3'd7;

  localparam logic [7:0] CMD_SPK_ON   = 8'hd1;
  localparam logic [7:0] CMD_SPK_OFF  = 8'hd3;
  localparam logic [7:0] CMD_TC       = 8'h40;
  localparam logic [7:0] CMD_BLK      = 8'h48;
  localparam logic [7:0] CMD_SC_OUT   = 8'h14;
  localparam logic [7:0] CMD_SC_IN    = 8'h24;
  localparam logic [7:0] CMD_AI_OUT   = 8'h1c;
  localparam logic [7:0] CMD_AI_IN    = 8'h2c;
  localparam logic [7:0] CMD_HS_OUT   = 8'h90;
  localparam logic [7:0] CMD_HS_IN    = 8'h98;
  localparam logic [7:0] CMD_EXIT8    = 8'hda;
  localparam logic [7:0] CMD_EXIT16   = 8'hd9;
  localparam logic [7:0] CMD_RATE_OUT = 8'h41;
  localparam logic [7:0] CMD_RATE_IN  = 8'h42;
  localparam logic [7:0] CMD_16_OUT   = 8'hb6;
  localparam logic [7:0] CMD_16_IN    = 8'hbe;
  localparam logic [7:0] CMD_8_OUT    = 8'hc6;
  localparam logic [7:0] CMD_8_IN     = 8'hce;
  localparam logic [7:0] MODE16_ST    = 8'h30;
  localparam logic [7:0] MODE16_MO    = 8'h10;
  localparam logic [7:0] MODE8_ST     = 8'h20;
  localparam logic [7:0] MODE8_MO     = 8'h00;
  localparam logic [7:0] CMD_IN_ST    = 8'ha8;
  localparam logic [7:0] CMD_IN_MO    = 8'ha0;
  localparam logic [7:0] ACK_8        = 8'd14;
  localparam logic [7:0] ACK_16       = 8'd15;

  localparam logic [27:0] TC_DIVIDEND = 28'd256000000;
  localparam logic [15:0] TC_BASE     = 16'h0080;
  localparam logic [15:0] HS_RATE     = 16'd23000;

endpackage
`default_nettype wire

// ----- hdl/dats_front.sv -----
`default_nettype none
module dats_front
  import dats_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  output logic          full,
  input  wire in_item_t item,
  input  wire logic [3:0] ver_major,
  input  wire logic     pop,
  output logic          valid,
  output cls_t          cls
);

  cls_t        mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  cls_t        c;
  logic [2:0]  oc, ic, dc;
  logic [16:0] size;

  always_comb begin
    oc = item.out_channels;
    ic = item.in_channels;
    c = '0;
    c.action = item.action;
    c.irq = item.irq_flags;
    c.rate = item.rate_hz;
    c.rec = (ic != 3'd0);
    dc = c.rec ? ic : oc;
    c.stereo = (dc == 3'd2);
    size = c.stereo ? {item.frames_per_half, 1'b0} : {1'b0, item.frames_per_half};
    c.eff = c.stereo ? {item.rate_hz, 1'b0} : {1'b0, item.rate_hz};
    c.bsm1 = 16'(size - 17'd1);
    c.err_v = 1'b1;
    if (oc > 3'd2 || ic > 3'd2) begin
      c.err = E_CHAN;
    end else if ((oc > 3'd1 || ic > 3'd1) && ver_major < 4'd3) begin
      c.err = E_STEREO;
    end else if (oc != 3'd0 && ic != 3'd0) begin
      c.err = E_DUPLEX;
    end else if (oc == 3'd0 && ic == 3'd0) begin
      c.err = E_NODIR;
    end else if (size == 17'd0) begin
      c.err = E_ZERO;
    end else if (size > 17'd65536) begin
      c.err = E_BIG;
    end else if (item.rate_hz == 16'd0) begin
      c.err = E_RATE;
    end else begin
      c.err_v = 1'b0;
    end
  end

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign cls   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wp_r <= ~wp_r;
      end
      if (pop && valid) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dats_div.sv -----
`default_nettype none
module dats_div
  import dats_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [16:0] divisor,
  output logic             done,
  output logic [27:0]      quot
);

  logic        busy_r;
  logic [4:0]  cnt_r;
  logic [16:0] rem_r;
  logic [16:0] dvs_r;
  logic [27:0] q_r;
  logic [17:0] trial;
  logic        ge;

  assign trial = {rem_r, TC_DIVIDEND[5'd27 - cnt_r]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign quot  = q_r;

  always_ff @(posedge clk) begin
    if (start) begin
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? 17'(trial - {1'b0, dvs_r}) : trial[16:0];
      q_r   <= {q_r[26:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd27) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dats_oq.sv -----
`default_nettype none
module dats_oq
  import dats_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire out_item_t din,
  output logic           full,
  input  wire logic      pop,
  output logic           empty,
  output out_item_t      dout
);

  out_item_t  mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push && !full) begin
        wp_r <= ~wp_r;
      end
      if (pop && !empty) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dats_back.sv -----
`default_nettype none
module dats_back
  import dats_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       valid,
  input  wire cls_t       cls,
  output logic            pop,
  input  wire logic [3:0] ver_major,
  input  wire logic [7:0] ver_minor,
  input  wire logic       s16,
  output logic            div_start,
  output logic [16:0]     div_divisor,
  input  wire logic       div_done,
  input  wire logic [27:0] div_quot,
  output logic            oq_push,
  output out_item_t       oq_din,
  input  wire logic       oq_full
);

  typedef enum logic [3:0] {
    B_IDLE  = 4'b0001,
    B_DIV   = 4'b0010,
    B_BUILD = 4'b0100,
    B_EMIT  = 4'b1000
  } bstate_t;

  bstate_t     st_r;
  cls_t        cur_r;
  logic [7:0]  tc_r;
  logic [2:0]  run_r, run_nxt;
  logic        rec_r, rec_nxt;
  logic        stereo_r, stereo_nxt;
  logic [15:0] bsm1_r, bsm1_nxt;
  logic        page_r, page_nxt;
  out_item_t   res_r [8];
  out_item_t   res [8];
  logic [3:0]  cnt_r, n;
  logic [2:0]  idx_r;
  logic        busy, need_div;
  logic [15:0] tc_w;
  logic [3:0]  lastix;

  function automatic out_item_t mk(logic [2:0] k, logic [7:0] v, logic ph, logic rc);
    out_item_t o;
    o.kind = k;
    o.value = v;
    o.page_high = ph;
    o.is_recording = rc;
    o.last = 1'b0;
    return o;
  endfunction

  assign busy = (run_r != RS_IDLE) && (run_r != RS_STOPPING);
  assign need_div = (cls.action == A_START) && !busy && !cls.err_v && !s16
                    && (ver_major != 4'd4);
  assign pop = (st_r == B_IDLE) && valid;
  assign div_start = pop && need_div;
  assign div_divisor = cls.eff;
  assign tc_w = TC_BASE - div_quot[15:0];
  assign oq_push = (st_r == B_EMIT) && !oq_full;
  assign oq_din = res_r[idx_r];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      res[i] = '0;
    end
    n = 4'd0;
    lastix = 4'd0;
    run_nxt = run_r;
    rec_nxt = rec_r;
    stereo_nxt = stereo_r;
    bsm1_nxt = bsm1_r;
    page_nxt = page_r;
    case (cur_r.action)
      A_START: begin
        if (busy) begin
          res[n[2:0]] = mk(K_ERR, {5'd0, E_BUSY}, 1'b0, 1'b0); n = n + 4'd1;
        end else if (cur_r.err_v) begin
          if (cur_r.err == E_ZERO || cur_r.err == E_BIG || cur_r.err == E_RATE) begin
            rec_nxt = cur_r.rec;
            stereo_nxt = cur_r.stereo;
          end
          res[n[2:0]] = mk(K_ERR, {5'd0, cur_r.err}, 1'b0, 1'b0); n = n + 4'd1;
        end else begin
          rec_nxt = cur_r.rec;
          stereo_nxt = cur_r.stereo;
          bsm1_nxt = cur_r.bsm1;
          page_nxt = 1'b1;
          res[n[2:0]] = mk(K_CMD, cur_r.rec ? CMD_SPK_OFF : CMD_SPK_ON, 1'b0, 1'b0);
          n = n + 4'd1;
          if (s16 || ver_major == 4'd4) begin
            res[n[2:0]] = mk(K_CMD, cur_r.rec ? CMD_RATE_IN : CMD_RATE_OUT, 1'b0, 1'b0);
            n = n + 4'd1;
            res[n[2:0]] = mk(K_CMD, cur_r.rate[15:8], 1'b0, 1'b0); n = n + 4'd1;
            res[n[2:0]] = mk(K_CMD, cur_r.rate[7:0], 1'b0, 1'b0); n = n + 4'd1;
            if (s16) begin
              run_nxt = RS_DMA16;
              res[n[2:0]] = mk(K_CMD, cur_r.rec ? CMD_16_IN : CMD_16_OUT, 1'b0, 1'b0);
              n = n + 4'd1;
              res[n[2:0]] = mk(K_CMD, cur_r.stereo ? MODE16_ST : MODE16_MO, 1'b0, 1'b0);
              n = n + 4'd1;
            end else begin
              run_nxt = RS_SB16_8;
              res[n[2:0]] = mk(K_CMD, cur_r.rec ? CMD_8_IN : CMD_8_OUT, 1'b0, 1'b0);
              n = n + 4'd1;
              res[n[2:0]] = mk(K_CMD, cur_r.stereo ? MODE8_ST : MODE8_MO, 1'b0, 1'b0);
              n = n + 4'd1;
            end
            res[n[2:0]] = mk(K_CMD, cur_r.bsm1[7:0], 1'b0, 1'b0); n = n + 4'd1;
            res[n[2:0]] = mk(K_CMD, cur_r.bsm1[15:8], 1'b0, 1'b0); n = n + 4'd1;
          end else begin
            res[n[2:0]] = mk(K_CMD, CMD_TC, 1'b0, 1'b0); n = n + 4'd1;
            res[n[2:0]] = mk(K_CMD, tc_r, 1'b0, 1'b0); n = n + 4'd1;
            if (ver_major == 4'd1) begin
              run_nxt = RS_SINGLE;
              res[n[2:0]] = mk(K_CMD, cur_r.rec ? CMD_SC_IN : CMD_SC_OUT, 1'b0, 1'b0);
              n = n + 4'd1;
              res[n[2:0]] = mk(K_CMD, cur_r.bsm1[7:0], 1'b0, 1'b0); n = n + 4'd1;
              res[n[2:0]] = mk(K_CMD, cur_r.bsm1[15:8], 1'b0, 1'b0); n = n + 4'd1;
            end else begin
              if (ver_major == 4'd3 && cur_r.rec) begin
                res[n[2:0]] = mk(K_CMD, cur_r.stereo ? CMD_IN_ST : CMD_IN_MO, 1'b0, 1'b0);
                n = n + 4'd1;
              end
              res[n[2:0]] = mk(K_CMD, CMD_BLK, 1'b0, 1'b0); n = n + 4'd1;
              res[n[2:0]] = mk(K_CMD, cur_r.bsm1[7:0], 1'b0, 1'b0); n = n + 4'd1;
              res[n[2:0]] = mk(K_CMD, cur_r.bsm1[15:8], 1'b0, 1'b0); n = n + 4'd1;
              if (((ver_major == 4'd2 && ver_minor != 8'd0) || ver_major > 4'd2)
                  && (cur_r.stereo || cur_r.rate >= HS_RATE)) begin
                run_nxt = RS_HS;
                res[n[2:0]] = mk(K_CMD, cur_r.rec ? CMD_HS_IN : CMD_HS_OUT, 1'b0, 1'b0);
              end else begin
                run_nxt = RS_LEGACY_8;
                res[n[2:0]] = mk(K_CMD, cur_r.rec ? CMD_AI_IN : CMD_AI_OUT, 1'b0, 1'b0);
              end
              n = n + 4'd1;
            end
          end
        end
      end
      A_STOP: begin
        case (run_r)
          RS_SINGLE: begin
            run_nxt = RS_STOPPING;
          end
          RS_SB16_8, RS_LEGACY_8, RS_DMA16, RS_HS: begin
            if (run_r == RS_DMA16) begin
              res[n[2:0]] = mk(K_CMD, CMD_EXIT16, 1'b0, 1'b0);
            end else if (run_r == RS_HS) begin
              res[n[2:0]] = mk(K_RESET, 8'd0, 1'b0, 1'b0);
            end else begin
              res[n[2:0]] = mk(K_CMD, CMD_EXIT8, 1'b0, 1'b0);
            end
            n = n + 4'd1;
            run_nxt = RS_IDLE;
            res[n[2:0]] = mk(K_CMD, CMD_SPK_OFF, 1'b0, 1'b0); n = n + 4'd1;
          end
          default: begin
          end
        endcase
      end
      A_IRQ: begin
        case (run_r)
          RS_STOPPING: begin
            run_nxt = RS_IDLE;
            res[n[2:0]] = mk(K_CMD, CMD_SPK_OFF, 1'b0, 1'b0); n = n + 4'd1;
          end
          RS_SINGLE: begin
            res[n[2:0]] = mk(K_CMD, rec_r ? CMD_SC_IN : CMD_SC_OUT, 1'b0, 1'b0);
            n = n + 4'd1;
            res[n[2:0]] = mk(K_CMD, bsm1_r[7:0], 1'b0, 1'b0); n = n + 4'd1;
            res[n[2:0]] = mk(K_CMD, bsm1_r[15:8], 1'b0, 1'b0); n = n + 4'd1;
            page_nxt = ~page_r;
            res[n[2:0]] = mk(K_READY, 8'd0, ~page_r, rec_r); n = n + 4'd1;
          end
          RS_LEGACY_8, RS_HS, RS_SB16_8, RS_DMA16: begin
            if ((run_r == RS_SB16_8 && !cur_r.irq[0]) ||
                (run_r == RS_DMA16 && !cur_r.irq[1])) begin
            end else begin
              res[n[2:0]] = mk(K_ACK, (run_r == RS_DMA16) ? ACK_16 : ACK_8, 1'b0, 1'b0);
              n = n + 4'd1;
              page_nxt = ~page_r;
              res[n[2:0]] = mk(K_READY, 8'd0, ~page_r, rec_r); n = n + 4'd1;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    if (n != 4'd0) begin
      lastix = n - 4'd1;
      res[lastix[2:0]].last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= cls;
    end
    if (div_done) begin
      tc_r <= tc_w[15:8];
    end
    if (st_r == B_BUILD) begin
      res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      run_r    <= RS_IDLE;
      rec_r    <= 1'b0;
      stereo_r <= 1'b0;
      bsm1_r   <= '0;
      page_r   <= 1'b1;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      case (st_r)
        B_IDLE: begin
          if (valid) begin
            st_r <= need_div ? B_DIV : B_BUILD;
          end
        end
        B_DIV: begin
          if (div_done) begin
            st_r <= B_BUILD;
          end
        end
        B_BUILD: begin
          run_r    <= run_nxt;
          rec_r    <= rec_nxt;
          stereo_r <= stereo_nxt;
          bsm1_r   <= bsm1_nxt;
          page_r   <= page_nxt;
          cnt_r    <= n;
          idx_r    <= '0;
          st_r     <= (n == 4'd0) ? B_IDLE : B_EMIT;
        end
        B_EMIT: begin
          if (!oq_full) begin
            idx_r <= idx_r + 3'd1;
            if ({1'b0, idx_r} == cnt_r - 4'd1) begin
              st_r <= B_IDLE;
            end
          end
        end
        default: begin
          st_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hdl/dsp_audio_transfer_sequencer_unit.sv -----
// an accepted item passes through the back end states idle, build and emit; a start that needs the
// serial time-constant divider (older dsps, 28 quotient bits one a cycle) waits in the divide state
// before build; then one result a cycle while the output queue is not full, up to 8 per item
// the next item is taken only after every result of the current one has been pushed
// reset (synchronous, rst_n low): queues empty, state idle, upper page marked, version 4.0
`default_nettype none
module dsp_audio_transfer_sequencer_unit
  import dats_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire in_item_t   in_data,
  output logic            out_empty,
  input  wire logic       out_pop,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [3:0]  maj_r;
  logic [7:0]  min_r;
  logic        s16_r;
  logic        f_valid, f_pop;
  cls_t        f_cls;
  logic        d_start, d_done;
  logic [16:0] d_divisor;
  logic [27:0] d_quot;
  logic        q_push, q_full;
  out_item_t   q_din;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maj_r <= 4'd4;
      min_r <= 8'd0;
      s16_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAJOR: maj_r <= cfg_data[3:0];
        CFG_MINOR: min_r <= cfg_data;
        CFG_S16:   s16_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  dats_front u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .full(in_full), .item(in_data),
    .ver_major(maj_r), .pop(f_pop), .valid(f_valid), .cls(f_cls)
  );

  dats_div u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .divisor(d_divisor),
    .done(d_done), .quot(d_quot)
  );

  dats_back u_back (
    .clk(clk), .rst_n(rst_n), .valid(f_valid), .cls(f_cls), .pop(f_pop),
    .ver_major(maj_r), .ver_minor(min_r), .s16(s16_r),
    .div_start(d_start), .div_divisor(d_divisor), .div_done(d_done), .div_quot(d_quot),
    .oq_push(q_push), .oq_din(q_din), .oq_full(q_full)
  );

  dats_oq u_oq (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_din), .full(q_full),
    .pop(out_pop), .empty(out_empty), .dout(out_data)
  );

endmodule
`default_nettype wire
